>>> rtl/pmf_pkg.sv
// Shared types, register indexes and saturation helpers for the planar motion step.
package pmf_pkg;

  localparam int W = 32;
  localparam int F = 16;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               on_ground;
    logic [15:0]        time_step;
  } item_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
  } result_t;

  localparam logic [2:0] CFG_MASS      = 3'd0;
  localparam logic [2:0] CFG_INIT_SPD  = 3'd1;
  localparam logic [2:0] CFG_MAX_SPD   = 3'd2;
  localparam logic [2:0] CFG_FRICTION  = 3'd3;
  localparam logic [2:0] CFG_GRAV_EN   = 3'd4;
  localparam logic [2:0] CFG_GRAV_X    = 3'd5;
  localparam logic [2:0] CFG_GRAV_Y    = 3'd6;

  localparam logic [31:0] MASS_RESET = 32'h0001_0000;
  localparam logic [31:0] SNAP_THR   = 32'd150 << F;
  localparam logic [63:0] SNAP_THR2  = 64'(SNAP_THR) * 64'(SNAP_THR);
  localparam logic [31:0] DIV_HEAVY  = 32'd3;

  localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sgn_from(input logic [63:0] m, input logic neg);
    logic [31:0] lo;
    lo = m[31:0];
    if (neg) begin
      if (m >= 64'h8000_0000) return VMIN;
      return -lo;
    end
    if (m > 64'h7FFF_FFFF) return VMAX;
    return lo;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? VMIN : VMAX;
    return s[31:0];
  endfunction

endpackage

>>> rtl/pmf_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module pmf_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [5:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand  <= {32'd0, a};
        mplier <= b;
        prod   <= '0;
        cnt    <= 6'd32;
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/pmf_div.sv
// Restoring divider, one quotient bit per cycle.
module pmf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] nsh;
  logic [31:0] rem;
  logic [31:0] dreg;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rs;
  logic        ge;

  assign rs = {rem, nsh[63]};
  assign ge = rs >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nsh  <= num;
        dreg <= den;
        rem  <= '0;
        quo  <= '0;
        cnt  <= 7'd64;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 32'(rs - {1'b0, dreg}) : rs[31:0];
        quo  <= {quo[62:0], ge};
        nsh  <= nsh << 1;
        cnt  <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/pmf_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
module pmf_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] xs;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] rs;
  logic [35:0] trial;
  logic        ge;

  assign rs    = {rem, xs[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs   <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'd32;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 34'(rs - trial) : rs[33:0];
        root <= {root[30:0], ge};
        xs   <= xs << 2;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/planar_motion_friction_step.sv
// Top level: frame sequencer for planar motion with ground friction.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------
//  item     | item_valid/item_ready  | item_data   (item_t)
//  result   | result_valid/ready     | result_data (result_t)
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Each beat is worked through step by step on the bit-serial divider,
// multiplier and square root, one unit at a time.
// Reset clears velocity and loads mass 1.0, other configuration registers zero.
// A new beat is taken once the sequencer is idle; a result waiting in
// the output register does not block it. cfg_ready is always high.
module planar_motion_friction_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pmf_pkg::item_t   item_data,
  output logic             result_valid,
  input  logic             result_ready,
  output pmf_pkg::result_t result_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    STP_DIVX, STP_DIVY, STP_GRAV, STP_SQX, STP_SQY, STP_CHK, STP_NORM,
    STP_DDX, STP_DDY, STP_SQRT, STP_MISX, STP_QX, STP_MISY, STP_QY,
    STP_MDTX, STP_MDTY, STP_FRQ, STP_FRDIV, STP_FRMUL, STP_OUTX, STP_OUTY
  } step_t;

  state_t state;
  step_t  step;

  logic [31:0]        mass;
  logic [30:0]        init_spd;
  logic signed [31:0] max_spd;
  logic [30:0]        fric;
  logic               grav_en;
  logic signed [31:0] grav_x;
  logic signed [31:0] grav_y;

  logic signed [31:0] vx, vy, ax, ay, outx, outy;
  logic signed [31:0] fx, fy;
  logic               gnd;
  logic [15:0]        dt;
  logic [31:0]        dx, dy, len;
  logic [63:0]        acc;
  logic [30:0]        fmag;

  logic        mul_start, div_start, sq_start;
  logic [31:0] mul_a, mul_b, div_den;
  logic [63:0] div_num, sq_x;
  logic        mul_done, div_done, sq_done;
  logic [63:0] mul_prod, div_quo;
  logic [31:0] sq_root;

  logic [31:0] ux, uy, mx, stepm;
  logic        slow;

  pmf_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod(mul_prod));
  pmf_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
                 .done(div_done), .quo(div_quo));
  pmf_sqrt u_sqrt (.clk, .rst, .start(sq_start), .radicand(sq_x),
                   .done(sq_done), .root(sq_root));

  assign item_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign ux    = pmf_pkg::mag32(vx);
  assign uy    = pmf_pkg::mag32(vy);
  assign mx    = (dx > dy) ? dx : dy;
  assign stepm = mul_prod[47:16];
  assign slow  = (ux < pmf_pkg::SNAP_THR) && (uy < pmf_pkg::SNAP_THR) &&
                 (acc < pmf_pkg::SNAP_THR2);

  always_ff @(posedge clk) begin
    if (rst) begin
      mass     <= pmf_pkg::MASS_RESET;
      init_spd <= '0;
      max_spd  <= '0;
      fric     <= '0;
      grav_en  <= 1'b0;
      grav_x   <= '0;
      grav_y   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmf_pkg::CFG_MASS:     mass     <= cfg_data;
        pmf_pkg::CFG_INIT_SPD: init_spd <= cfg_data[30:0];
        pmf_pkg::CFG_MAX_SPD:  max_spd  <= cfg_data;
        pmf_pkg::CFG_FRICTION: fric     <= cfg_data[30:0];
        pmf_pkg::CFG_GRAV_EN:  grav_en  <= cfg_data[0];
        pmf_pkg::CFG_GRAV_X:   grav_x   <= cfg_data;
        pmf_pkg::CFG_GRAV_Y:   grav_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= STP_DIVX;
      vx           <= '0;
      vy           <= '0;
      result_valid <= 1'b0;
      mul_start    <= 1'b0;
      div_start    <= 1'b0;
      sq_start     <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      if (result_valid && result_ready && state != ST_DONE) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            fx    <= item_data.force_x;
            fy    <= item_data.force_y;
            gnd   <= item_data.on_ground;
            dt    <= item_data.time_step;
            step  <= STP_DIVX;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          case (step)
            STP_DIVX: begin
              if (fx == 0) begin
                ax <= '0; step <= STP_DIVY;
              end else if (mass == 0) begin
                ax <= fx[31] ? pmf_pkg::VMIN : pmf_pkg::VMAX; step <= STP_DIVY;
              end else begin
                div_num <= {16'd0, pmf_pkg::mag32(fx), 16'd0};
                div_den <= mass; div_start <= 1'b1; state <= ST_WAIT;
              end
            end
            STP_DIVY: begin
              if (fy == 0) begin
                ay <= '0; step <= STP_GRAV;
              end else if (mass == 0) begin
                ay <= fy[31] ? pmf_pkg::VMIN : pmf_pkg::VMAX; step <= STP_GRAV;
              end else begin
                div_num <= {16'd0, pmf_pkg::mag32(fy), 16'd0};
                div_den <= mass; div_start <= 1'b1; state <= ST_WAIT;
              end
            end
            STP_GRAV: begin
              if (grav_en && !gnd) begin
                ax <= pmf_pkg::sat_add(ax, grav_x);
                ay <= pmf_pkg::sat_add(ay, grav_y);
              end
              step <= STP_SQX;
            end
            STP_SQX: begin
              mul_a <= ux; mul_b <= ux; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_SQY: begin
              mul_a <= uy; mul_b <= uy; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_CHK: begin
              if (slow) begin
                if (ax != 0 || ay != 0) begin
                  dx <= pmf_pkg::mag32(ax); dy <= pmf_pkg::mag32(ay); step <= STP_NORM;
                end else begin
                  step <= STP_FRQ;
                end
              end else begin
                step <= STP_MDTX;
              end
            end
            STP_NORM: begin
              if (mx[31]) begin
                dx <= dx >> 1; dy <= dy >> 1;
              end else if (!mx[30]) begin
                dx <= dx << 1; dy <= dy << 1;
              end else begin
                step <= STP_DDX;
              end
            end
            STP_DDX: begin
              mul_a <= dx; mul_b <= dx; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_DDY: begin
              mul_a <= dy; mul_b <= dy; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_SQRT: begin
              sq_x <= acc; sq_start <= 1'b1; state <= ST_WAIT;
            end
            STP_MISX: begin
              mul_a <= dx; mul_b <= {1'b0, init_spd}; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_MISY: begin
              mul_a <= dy; mul_b <= {1'b0, init_spd}; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_QX, STP_QY: begin
              div_num <= acc; div_den <= len; div_start <= 1'b1; state <= ST_WAIT;
            end
            STP_MDTX: begin
              mul_a <= pmf_pkg::mag32(ax); mul_b <= {16'd0, dt};
              mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_MDTY: begin
              mul_a <= pmf_pkg::mag32(ay); mul_b <= {16'd0, dt};
              mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_FRQ: begin
              if (vx != 0 && gnd) begin
                if (fx == 0 && fy == 0) begin
                  fmag <= fric; step <= STP_FRDIV;
                end else if (max_spd > vx) begin
                  div_num <= {33'd0, fric}; div_den <= pmf_pkg::DIV_HEAVY;
                  div_start <= 1'b1; state <= ST_WAIT;
                end else begin
                  fmag <= fric >> 2; step <= STP_FRDIV;
                end
              end else begin
                step <= STP_OUTX;
              end
            end
            STP_FRDIV: begin
              if (fmag == 0) begin
                step <= STP_OUTX;
              end else if (mass == 0) begin
                ax <= pmf_pkg::VMAX; step <= STP_FRMUL;
              end else begin
                div_num <= {17'd0, fmag, 16'd0}; div_den <= mass;
                div_start <= 1'b1; state <= ST_WAIT;
              end
            end
            STP_FRMUL: begin
              mul_a <= ax; mul_b <= {16'd0, dt}; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_OUTX: begin
              mul_a <= ux; mul_b <= {16'd0, dt}; mul_start <= 1'b1; state <= ST_WAIT;
            end
            STP_OUTY: begin
              mul_a <= uy; mul_b <= {16'd0, dt}; mul_start <= 1'b1; state <= ST_WAIT;
            end
            default: step <= STP_OUTX;
          endcase
        end
        ST_WAIT: begin
          if (mul_done || div_done || sq_done) begin
            state <= (step == STP_OUTY) ? ST_DONE : ST_RUN;
            case (step)
              STP_DIVX:  begin ax <= pmf_pkg::sgn_from(div_quo, fx[31]); step <= STP_DIVY; end
              STP_DIVY:  begin ay <= pmf_pkg::sgn_from(div_quo, fy[31]); step <= STP_GRAV; end
              STP_SQX:   begin acc <= mul_prod; step <= STP_SQY; end
              STP_SQY:   begin acc <= acc + mul_prod; step <= STP_CHK; end
              STP_DDX:   begin acc <= mul_prod; step <= STP_DDY; end
              STP_DDY:   begin acc <= acc + mul_prod; step <= STP_SQRT; end
              STP_SQRT:  begin len <= sq_root; step <= STP_MISX; end
              STP_MISX:  begin acc <= mul_prod; step <= STP_QX; end
              STP_QX:    begin vx <= pmf_pkg::sgn_from(div_quo, ax[31]); step <= STP_MISY; end
              STP_MISY:  begin acc <= mul_prod; step <= STP_QY; end
              STP_QY:    begin vy <= pmf_pkg::sgn_from(div_quo, ay[31]); step <= STP_FRQ; end
              STP_MDTX: begin
                vx <= pmf_pkg::sat_add(vx, pmf_pkg::sgn_from(mul_prod >> 16, ax[31]));
                step <= STP_MDTY;
              end
              STP_MDTY: begin
                vy <= pmf_pkg::sat_add(vy, pmf_pkg::sgn_from(mul_prod >> 16, ay[31]));
                step <= STP_FRQ;
              end
              STP_FRQ:   begin fmag <= div_quo[30:0]; step <= STP_FRDIV; end
              STP_FRDIV: begin ax <= pmf_pkg::sgn_from(div_quo, 1'b0); step <= STP_FRMUL; end
              STP_FRMUL: begin
                if (ux < stepm) vx <= '0;
                else if (!vx[31]) vx <= vx - stepm;
                else vx <= vx + stepm;
                step <= STP_OUTX;
              end
              STP_OUTX: begin
                outx <= pmf_pkg::sgn_from(mul_prod >> 16, vx[31]); step <= STP_OUTY;
              end
              STP_OUTY: begin
                outy <= pmf_pkg::sgn_from(mul_prod >> 16, vy[31]);
              end
              default: step <= STP_OUTX;
            endcase
          end
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_data.velocity_x <= vx;
            result_data.velocity_y <= vy;
            result_data.move_x     <= outx;
            result_data.move_y     <= outy;
            result_valid           <= 1'b1;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    (mul_done || div_done || sq_done) |-> state == ST_WAIT)
    else $error("arithmetic unit finished outside wait");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!result_valid || result_ready)) |=>
      (state == ST_IDLE && result_valid))
    else $error("finished beat not loaded into result register");

endmodule
